@@ rtl/mlpq_pkg.sv @@
package mlpq_pkg;

   localparam int LEVEL_COUNT_DEF = 4;
   localparam int FIFO_DEPTH_DEF = 64;
   localparam int VALUE_BITS_DEF = 32;

   localparam int OP_BITS = 2;
   localparam int STATUS_BITS = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_SHIFT = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Per-request outcome handed from the control unit to the response stage.
   typedef struct packed {
      logic       hit;
      status_type status;
   } result_type;

endpackage

@@ rtl/mlpq_ram.sv @@
module mlpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mlpq_ctrl.sv @@
module mlpq_ctrl #(
   parameter int LEVEL_COUNT = mlpq_pkg::LEVEL_COUNT_DEF,
   parameter int FIFO_DEPTH = mlpq_pkg::FIFO_DEPTH_DEF,
   parameter int VALUE_BITS = mlpq_pkg::VALUE_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          accept,
   input  mlpq_pkg::op_type                              op,
   input  logic [$clog2(LEVEL_COUNT)-1:0]                level,
   input  logic [VALUE_BITS-1:0]                         value,
   output mlpq_pkg::result_type                          result,
   output logic [$clog2(LEVEL_COUNT)-1:0]                pop_level,
   output logic                                          wr_en,
   output logic [$clog2(LEVEL_COUNT*FIFO_DEPTH)-1:0]     wr_addr,
   output logic [VALUE_BITS-1:0]                         wr_data,
   output logic                                          rd_en,
   output logic [$clog2(LEVEL_COUNT*FIFO_DEPTH)-1:0]     rd_addr
);

   localparam int LB = $clog2(LEVEL_COUNT);
   localparam int CB = $clog2(FIFO_DEPTH + 1);
   localparam int HB = $clog2(FIFO_DEPTH);
   localparam int AB = $clog2(LEVEL_COUNT * FIFO_DEPTH);
   localparam logic [LB:0] LC_W = (LB+1)'(LEVEL_COUNT);
   localparam logic [CB:0] DEPTH_W = (CB+1)'(FIFO_DEPTH);

   logic [CB-1:0] count_ff [LEVEL_COUNT];
   logic [CB-1:0] count_in [LEVEL_COUNT];
   logic [HB-1:0] head_ff [LEVEL_COUNT];
   logic [HB-1:0] head_in [LEVEL_COUNT];
   logic [LB-1:0] base_ff;
   logic [LB-1:0] base_in;

   logic [LB-1:0] phys_slot [LEVEL_COUNT];
   logic [LB-1:0] level_mod;
   logic [LB-1:0] push_slot;
   logic          push_full;
   logic [CB:0]   wpos_sum;
   logic [HB-1:0] wpos;
   logic          pop_found;
   logic [LB-1:0] pop_logical;
   logic [LB-1:0] pop_slot;
   logic [HB-1:0] pop_head;
   logic [HB-1:0] pop_head_next;

   // Both operands are below the level count, so one subtraction folds the sum.
   function automatic logic [LB-1:0] wrap_slot(input logic [LB:0] s);
      return (s >= LC_W) ? LB'(s - LC_W) : LB'(s);
   endfunction

   // Logical level L lives in physical slot (base + L) mod LEVEL_COUNT.
   for (genvar l = 0; l < LEVEL_COUNT; l++) begin : g_slot
      assign phys_slot[l] = wrap_slot((LB+1)'(base_ff) + (LB+1)'(l));
   end

   always_comb begin
      level_mod = wrap_slot((LB+1)'(level));
      push_slot = wrap_slot((LB+1)'(base_ff) + (LB+1)'(level_mod));
      push_full = (count_ff[push_slot] == CB'(FIFO_DEPTH));
      wpos_sum = (CB+1)'(head_ff[push_slot]) + (CB+1)'(count_ff[push_slot]);
      wpos = (wpos_sum >= DEPTH_W) ? HB'(wpos_sum - DEPTH_W) : HB'(wpos_sum);
   end

   always_comb begin
      pop_found = 1'b0;
      pop_logical = '0;
      for (int l = LEVEL_COUNT - 1; l >= 0; l--) begin
         if (count_ff[phys_slot[l]] != '0) begin
            pop_found = 1'b1;
            pop_logical = LB'(l);
         end
      end
      pop_slot = phys_slot[pop_logical];
      pop_head = head_ff[pop_slot];
      pop_head_next = (pop_head == HB'(FIFO_DEPTH - 1)) ? '0 : pop_head + 1'b1;
   end

   always_comb begin
      count_in = count_ff;
      head_in = head_ff;
      base_in = base_ff;
      result.hit = 1'b0;
      result.status = mlpq_pkg::ST_DONE;
      wr_en = 1'b0;
      rd_en = 1'b0;
      if (accept) begin
         case (op)
            mlpq_pkg::OP_PUSH: begin
               if (push_full) begin
                  result.status = mlpq_pkg::ST_FULL;
               end else begin
                  count_in[push_slot] = count_ff[push_slot] + 1'b1;
                  wr_en = 1'b1;
               end
            end
            mlpq_pkg::OP_POP: begin
               if (pop_found) begin
                  result.hit = 1'b1;
                  count_in[pop_slot] = count_ff[pop_slot] - 1'b1;
                  head_in[pop_slot] = pop_head_next;
                  rd_en = 1'b1;
               end else begin
                  result.status = mlpq_pkg::ST_EMPTY;
               end
            end
            mlpq_pkg::OP_SHIFT: begin
               count_in[phys_slot[0]] = '0;
               head_in[phys_slot[0]] = '0;
               base_in = wrap_slot((LB+1)'(base_ff) + (LB+1)'(1));
            end
            default: begin
            end
         endcase
      end
   end

   assign pop_level = pop_logical;
   assign wr_addr = AB'(push_slot) * AB'(FIFO_DEPTH) + AB'(wpos);
   assign wr_data = value;
   assign rd_addr = AB'(pop_slot) * AB'(FIFO_DEPTH) + AB'(pop_head);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '{default: '0};
         head_ff <= '{default: '0};
         base_ff <= '0;
      end else begin
         count_ff <= count_in;
         head_ff <= head_in;
         base_ff <= base_in;
      end
   end

endmodule

@@ rtl/multilevel_priority_fifo_core.sv @@
// Multilevel priority FIFO: LEVEL_COUNT levels, each a bounded FIFO of FIFO_DEPTH handles,
// level 0 the most urgent. A request is a push (append to a level), a pop (take the head of
// the lowest-numbered non-empty level) or a shift (drop level 0, every other level moves one
// step up); each request gives exactly one response carrying a status. One request can be
// taken every clock cycle while the response side is not stalled; its response passes first
// through the registered read of the shared handle memory, then through the response register.
// The handle memory needs no clearing after reset, so the block is ready straight away.
module multilevel_priority_fifo_core #(
   parameter int LEVEL_COUNT = mlpq_pkg::LEVEL_COUNT_DEF,
   parameter int FIFO_DEPTH = mlpq_pkg::FIFO_DEPTH_DEF,
   parameter int VALUE_BITS = mlpq_pkg::VALUE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // value
   input  logic [((VALUE_BITS+7)/8)*8-1:0] req_tdata,
   // operation, level
   input  logic [mlpq_pkg::OP_BITS+$clog2(LEVEL_COUNT)-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_value
   output logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata,
   // out_level, status
   output logic [$clog2(LEVEL_COUNT)+mlpq_pkg::STATUS_BITS-1:0] rsp_tuser
);

   localparam int LB = $clog2(LEVEL_COUNT);
   localparam int AB = $clog2(LEVEL_COUNT * FIFO_DEPTH);
   localparam int DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int OPB = mlpq_pkg::OP_BITS;

   logic                  accept;
   logic                  s1_advance;
   mlpq_pkg::result_type  result;
   logic [LB-1:0]         pop_level;
   logic                  wr_en;
   logic [AB-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [AB-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   mlpq_pkg::result_type    s1_result_ff;
   mlpq_pkg::result_type    s1_result_in;
   logic [LB-1:0]           s1_level_ff;
   logic [LB-1:0]           s1_level_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff;
   logic [VALUE_BITS-1:0]   rsp_value_in;
   logic [LB-1:0]           rsp_level_ff;
   logic [LB-1:0]           rsp_level_in;
   mlpq_pkg::status_type    rsp_status_ff;
   mlpq_pkg::status_type    rsp_status_in;

   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign accept = req_tvalid && req_tready;

   mlpq_ctrl #(
      .LEVEL_COUNT(LEVEL_COUNT),
      .FIFO_DEPTH (FIFO_DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .op       (mlpq_pkg::op_type'(req_tuser[OPB-1:0])),
      .level    (req_tuser[OPB+LB-1:OPB]),
      .value    (req_tdata[VALUE_BITS-1:0]),
      .result   (result),
      .pop_level(pop_level),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr)
   );

   mlpq_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(LEVEL_COUNT * FIFO_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // The memory read data stays put until the next successful pop is accepted, which can
   // only happen in the same cycle as this stage hands its request on.
   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !s1_advance);
      s1_result_in = accept ? result : s1_result_ff;
      s1_level_in = accept ? pop_level : s1_level_ff;

      rsp_valid_in = (s1_valid_ff && s1_advance) || (rsp_valid_ff && !rsp_tready);
      rsp_value_in = rsp_value_ff;
      rsp_level_in = rsp_level_ff;
      rsp_status_in = rsp_status_ff;
      if (s1_valid_ff && s1_advance) begin
         rsp_value_in = s1_result_ff.hit ? rd_data : '0;
         rsp_level_in = s1_result_ff.hit ? s1_level_ff : '0;
         rsp_status_in = s1_result_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_result_ff <= s1_result_in;
      s1_level_ff <= s1_level_in;
      rsp_value_ff <= rsp_value_in;
      rsp_level_ff <= rsp_level_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = DATA_BITS'(rsp_value_ff);
   assign rsp_tuser = {rsp_status_ff, rsp_level_ff};

endmodule

@@ rtl/mlpq_checker.sv @@
module mlpq_checker #(
   parameter int LEVEL_BITS = 2,
   parameter int DATA_BITS = 32
) (
   input logic                                       clock,
   input logic                                       reset,
   input logic                                       req_tvalid,
   input logic                                       req_tready,
   input logic                                       rsp_tvalid,
   input logic                                       rsp_tready,
   input logic [DATA_BITS-1:0]                       rsp_tdata,
   input logic [LEVEL_BITS+mlpq_pkg::STATUS_BITS-1:0] rsp_tuser
);

   logic [LEVEL_BITS-1:0]            rsp_level;
   logic [mlpq_pkg::STATUS_BITS-1:0] rsp_status;

   assign rsp_level = rsp_tuser[LEVEL_BITS-1:0];
   assign rsp_status = rsp_tuser[LEVEL_BITS +: mlpq_pkg::STATUS_BITS];

   // A stalled response holds its content.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Only a successful pop carries a handle and a level.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != mlpq_pkg::ST_DONE |-> rsp_tdata == '0 && rsp_level == '0)
      else $error("failed request returned a handle or level");

   // A request taken while the response is stalled fills the middle stage.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid && !rsp_tready |=> rsp_tready || !req_tready)
      else $error("request taken with the pipeline full");

   // With the response side free behind it, an accepted request gives a response.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready ##1 (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("accepted request gave no response");

endmodule

bind multilevel_priority_fifo_core mlpq_checker #(
   .LEVEL_BITS($clog2(LEVEL_COUNT)),
   .DATA_BITS (((VALUE_BITS + 7) / 8) * 8)
) u_mlpq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

@@ test/tb_multilevel_priority_fifo_core.sv @@
`timescale 1ns / 1ps

module tb_multilevel_priority_fifo_core;

   localparam int LVL_BITS = $clog2(mlpq_pkg::LEVEL_COUNT_DEF);
   localparam int PTR_BITS = $clog2(mlpq_pkg::FIFO_DEPTH_DEF);
   localparam int VAL_BITS = mlpq_pkg::VALUE_BITS_DEF;
   localparam int DATA_BITS = ((VAL_BITS + 7) / 8) * 8;
   localparam int QUIET_LIMIT = 5000;
   localparam int REPORT_LIMIT = 10;

   // Mirrors the queue contents and holds the responses still owed by the block.
   class priority_queue_mirror;
      typedef struct {
         logic [VAL_BITS-1:0]  value;
         logic [LVL_BITS-1:0]  level;
         mlpq_pkg::status_type status;
      } response_type;

      logic [VAL_BITS-1:0] handles [mlpq_pkg::LEVEL_COUNT_DEF][mlpq_pkg::FIFO_DEPTH_DEF];
      logic [PTR_BITS-1:0] head [mlpq_pkg::LEVEL_COUNT_DEF];
      logic [PTR_BITS:0]   fill [mlpq_pkg::LEVEL_COUNT_DEF];
      logic [LVL_BITS-1:0] base;
      response_type        awaited [$];
      int                  mismatches;

      function new();
         base = '0;
         mismatches = 0;
         foreach (head[i]) begin
            head[i] = '0;
            fill[i] = '0;
         end
      endfunction

      function void note_request(mlpq_pkg::op_type op, logic [LVL_BITS-1:0] lvl,
                                 logic [VAL_BITS-1:0] val);
         response_type        r;
         logic [LVL_BITS-1:0] slot;
         logic [PTR_BITS-1:0] pos;
         bit                  found;
         int                  l;
         r.value = '0;
         r.level = '0;
         r.status = mlpq_pkg::ST_DONE;
         found = 1'b0;
         case (op)
            mlpq_pkg::OP_PUSH: begin
               // Logical level L lives in physical slot base + L, wrapping round.
               slot = base + lvl;
               if (fill[slot] == (PTR_BITS+1)'(mlpq_pkg::FIFO_DEPTH_DEF)) begin
                  r.status = mlpq_pkg::ST_FULL;
               end else begin
                  pos = head[slot] + fill[slot][PTR_BITS-1:0];
                  handles[slot][pos] = val;
                  fill[slot] = fill[slot] + 1'b1;
               end
            end
            mlpq_pkg::OP_POP: begin
               for (l = 0; l < mlpq_pkg::LEVEL_COUNT_DEF && !found; l++) begin
                  slot = base + l[LVL_BITS-1:0];
                  if (fill[slot] != 0) begin
                     found = 1'b1;
                     r.value = handles[slot][head[slot]];
                     r.level = l[LVL_BITS-1:0];
                     head[slot] = head[slot] + 1'b1;
                     fill[slot] = fill[slot] - 1'b1;
                  end
               end
               if (!found) r.status = mlpq_pkg::ST_EMPTY;
            end
            mlpq_pkg::OP_SHIFT: begin
               fill[base] = '0;
               head[base] = '0;
               base = base + 1'b1;
            end
            default: ;
         endcase
         awaited.push_back(r);
      endfunction

      function void check_response(logic [VAL_BITS-1:0] value, logic [LVL_BITS-1:0] level,
                                   logic [mlpq_pkg::STATUS_BITS-1:0] status);
         response_type r;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: value %h level %0d status %0d",
                        value, level, status);
         end else begin
            r = awaited.pop_front();
            if (r.value !== value || r.level !== level || r.status !== status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"response mismatch: expected value %h level %0d status %0d,",
                            " got value %h level %0d status %0d"},
                           r.value, r.level, r.status, value, level, status);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // value
   logic [DATA_BITS-1:0] req_tdata;
   // operation, level
   logic [mlpq_pkg::OP_BITS+LVL_BITS-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   // out_value
   logic [DATA_BITS-1:0] rsp_tdata;
   // out_level, status
   logic [LVL_BITS+mlpq_pkg::STATUS_BITS-1:0] rsp_tuser;

   bit quiet_tail = 1'b0;
   int quiet_cycles = 0;
   priority_queue_mirror mirror = new();

   multilevel_priority_fifo_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [VAL_BITS-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // The valid line stays high between back-to-back requests; a gap lowers it first.
   task automatic send_request(input mlpq_pkg::op_type op, input logic [LVL_BITS-1:0] lvl,
                               input logic [VAL_BITS-1:0] val);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {lvl, op};
      req_tdata <= val;
      do @(posedge clock); while (!req_tready);
      mirror.note_request(op, lvl, val);
   endtask

   // Weighted mix of requests, with the odd run of pushes to one level so that it fills up.
   task automatic run_phase(input int n, input int w_push, input int w_pop, input int w_shift);
      int                  sent;
      int                  pick;
      int                  run_len;
      logic [LVL_BITS-1:0] lvl;
      mlpq_pkg::op_type    op;
      sent = 0;
      while (sent < n) begin
         lvl = LVL_BITS'($urandom_range(0, mlpq_pkg::LEVEL_COUNT_DEF - 1));
         if ($urandom_range(0, 99) == 0) begin
            run_len = $urandom_range(mlpq_pkg::FIFO_DEPTH_DEF - 4,
                                     mlpq_pkg::FIFO_DEPTH_DEF + 6);
            repeat (run_len) send_request(mlpq_pkg::OP_PUSH, lvl, random_value());
            sent += run_len;
         end else begin
            pick = $urandom_range(0, w_push + w_pop + w_shift + 4);
            if (pick < w_push) op = mlpq_pkg::OP_PUSH;
            else if (pick < w_push + w_pop) op = mlpq_pkg::OP_POP;
            else if (pick < w_push + w_pop + w_shift) op = mlpq_pkg::OP_SHIFT;
            else op = mlpq_pkg::OP_NONE;
            send_request(op, lvl, random_value());
            sent++;
         end
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_response(rsp_tdata[VAL_BITS-1:0], rsp_tuser[LVL_BITS-1:0],
                               rsp_tuser[LVL_BITS+mlpq_pkg::STATUS_BITS-1:LVL_BITS]);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: pop reports empty, no-op and shift do nothing visible.
      send_request(mlpq_pkg::OP_POP, 2'd0, '0);
      send_request(mlpq_pkg::OP_NONE, 2'd2, 32'h1234_5678);
      send_request(mlpq_pkg::OP_SHIFT, 2'd1, '1);
      send_request(mlpq_pkg::OP_PUSH, 2'd0, '0);
      send_request(mlpq_pkg::OP_PUSH, 2'd1, '1);
      send_request(mlpq_pkg::OP_PUSH, 2'd2, 32'hA5A5_A5A5);
      send_request(mlpq_pkg::OP_PUSH, 2'd3, 32'h5A5A_5A5A);
      send_request(mlpq_pkg::OP_POP, 2'd3, '1);
      send_request(mlpq_pkg::OP_POP, 2'd0, '0);
      // Level 0 is empty now; the shift moves levels 2 and 3 up by one.
      send_request(mlpq_pkg::OP_SHIFT, 2'd0, '0);
      send_request(mlpq_pkg::OP_POP, 2'd1, 32'hFFFF_0000);
      send_request(mlpq_pkg::OP_POP, 2'd2, 32'h0000_FFFF);
      send_request(mlpq_pkg::OP_POP, 2'd3, '0);
      // A shift with a populated level 0 throws its contents away.
      send_request(mlpq_pkg::OP_PUSH, 2'd0, 32'h0000_0001);
      send_request(mlpq_pkg::OP_PUSH, 2'd3, 32'h8000_0000);
      send_request(mlpq_pkg::OP_SHIFT, 2'd3, '1);
      send_request(mlpq_pkg::OP_POP, 2'd0, '0);
      send_request(mlpq_pkg::OP_NONE, 2'd3, '1);
      send_request(mlpq_pkg::OP_POP, 2'd1, '1);

      run_phase(300, 50, 35, 5);
      run_phase(300, 20, 70, 5);
      run_phase(250, 40, 25, 30);
      run_phase(400, 45, 45, 5);
      quiet_tail = 1'b1;
      run_phase(350, 45, 45, 5);
      req_tvalid <= 1'b0;

      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mirror.awaited.size() != 0) begin
         $display("%0d responses never arrived", mirror.awaited.size());
         mirror.mismatches += mirror.awaited.size();
      end
      if (mirror.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
